// ===== sv/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
`timescale 1ns / 1ps

package deq_pkg;

  // Default number of ring entries.
  localparam int DEPTH_DEF = 16;

  // Fixed field widths.
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Command codes carried with each input transaction.
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                push_front;
    logic                push_back;
    logic                pop_front;
    logic                pop_back;
    logic                dump_start;
    logic                rd_dump;
    logic                load_imm;
    logic                load_rd;
    logic [STATUS_W-1:0] imm_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic out_free;
    logic out_valid;
    logic rd_pend;
    logic rd_last;
    logic dump_more;
  } sts_t;

endpackage

// ===== sv/deq_datapath.sv =====
// Datapath of the double-ended queue: ring memory, pointers and result register.
`timescale 1ns / 1ps

module deq_datapath #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  deq_pkg::cmd_t                 cmd,
  output deq_pkg::sts_t                 sts,
  input  logic [deq_pkg::VALUE_W-1:0]   in_value,
  input  logic                          out_tready,
  output logic                          out_valid,
  output logic [deq_pkg::VALUE_W-1:0]   out_value,
  output logic [deq_pkg::STATUS_W-1:0]  out_status,
  output logic [deq_pkg::COUNT_W-1:0]   out_count,
  output logic                          out_last
);
  import deq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int OW = $clog2(DEPTH + 1);
  localparam logic [OW-1:0] DEPTH_O     = OW'(DEPTH);
  localparam logic [OW-1:0] DEPTH_M1_O  = OW'(DEPTH - 1);
  localparam logic [OW:0]   DEPTH_S     = (OW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX    = IW'(DEPTH - 1);

  // Ring storage, one write or one read per cycle.
  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data_r;

  logic [IW-1:0] front_r, front_nxt;
  logic [OW-1:0] occ_r, occ_nxt;
  logic [OW-1:0] idx_r, idx_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic          rd_last_r, rd_last_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_value_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                out_last_r;

  logic [OW-1:0] offset;
  logic [OW:0]   addr_sum;
  logic [IW-1:0] addr;
  logic          wr_en, rd_en, load;

  assign wr_en = cmd.push_front | cmd.push_back;
  assign rd_en = cmd.pop_front | cmd.pop_back | cmd.rd_dump;
  assign load  = cmd.load_imm | cmd.load_rd;

  // Ring position: front plus an offset, wrapped once.
  always_comb begin
    offset = '0;
    if (cmd.push_front) begin
      offset = DEPTH_M1_O;
    end else if (cmd.push_back) begin
      offset = occ_r;
    end else if (cmd.pop_back) begin
      offset = occ_r - 1'b1;
    end else if (cmd.rd_dump) begin
      offset = idx_r;
    end
    addr_sum = (OW + 1)'(front_r) + (OW + 1)'(offset);
    if (addr_sum >= DEPTH_S) begin
      addr_sum = addr_sum - DEPTH_S;
    end
    addr = addr_sum[IW-1:0];
  end

  // Pointer, count and read tracking updates.
  always_comb begin
    front_nxt   = front_r;
    occ_nxt     = occ_r;
    idx_nxt     = idx_r;
    rd_pend_nxt = rd_pend_r;
    rd_last_nxt = rd_last_r;
    if (cmd.push_front) begin
      front_nxt = addr;
    end else if (cmd.pop_front) begin
      front_nxt = (front_r == LAST_IDX) ? '0 : front_r + 1'b1;
    end
    if (wr_en) begin
      occ_nxt = occ_r + 1'b1;
    end else if (cmd.pop_front | cmd.pop_back) begin
      occ_nxt = occ_r - 1'b1;
    end
    if (cmd.dump_start) begin
      idx_nxt = '0;
    end else if (cmd.rd_dump) begin
      idx_nxt = idx_r + 1'b1;
    end
    if (rd_en) begin
      rd_pend_nxt = 1'b1;
      rd_last_nxt = cmd.rd_dump ? (idx_r + 1'b1 == occ_r) : 1'b1;
    end else if (cmd.load_rd) begin
      rd_pend_nxt = 1'b0;
    end
    out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  // Memory port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= in_value;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      occ_r       <= '0;
      idx_r       <= '0;
      rd_pend_r   <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      idx_r       <= idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_value_r  <= cmd.load_rd ? rd_data_r : '0;
      out_status_r <= cmd.load_rd ? ST_OK : cmd.imm_status;
      out_count_r  <= COUNT_W'(occ_nxt);
      out_last_r   <= cmd.load_rd ? rd_last_r : 1'b1;
    end
  end

  assign sts.empty     = (occ_r == '0);
  assign sts.full      = (occ_r == DEPTH_O);
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.out_valid = out_valid_r;
  assign sts.rd_pend   = rd_pend_r;
  assign sts.rd_last   = rd_last_r;
  assign sts.dump_more = (idx_r != occ_r);

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  // The entry count never exceeds the ring size.
  a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_O)
    else $error("occupancy above depth");

  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !load)
    else $error("result register overwritten while stalled");

  // A read result is only taken once a read has been issued.
  a_rd_before_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_rd |-> rd_pend_r)
    else $error("read data consumed without a read");

  // A read is never started while unconsumed read data would be lost.
  a_rd_not_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && rd_pend_r) |-> cmd.load_rd)
    else $error("pending read data dropped");
`endif

endmodule

// ===== sv/deq_ctrl.sv =====
// Controller state machine of the double-ended queue.
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [deq_pkg::CMD_W-1:0]   in_command,
  input  deq_pkg::sts_t               sts,
  output deq_pkg::cmd_t               cmd
);
  import deq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE) && sts.out_free;
  assign accept    = in_tvalid && in_tready;

  // Command decode and sequencing.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_command) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              cmd.load_imm = 1'b1;
              if (sts.full) begin
                cmd.imm_status = ST_FULL;
              end else begin
                cmd.imm_status = ST_OK;
                cmd.push_front = (in_command == CMD_PUSH_FRONT);
                cmd.push_back  = (in_command == CMD_PUSH_BACK);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (sts.empty) begin
                cmd.load_imm   = 1'b1;
                cmd.imm_status = ST_UNDERFLOW;
              end else begin
                cmd.pop_front = (in_command == CMD_POP_FRONT);
                cmd.pop_back  = (in_command == CMD_POP_BACK);
                state_nxt     = S_POP;
              end
            end
            CMD_DUMP: begin
              if (sts.empty) begin
                cmd.load_imm   = 1'b1;
                cmd.imm_status = ST_EMPTY;
              end else begin
                cmd.dump_start = 1'b1;
                state_nxt      = S_DUMP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_POP: begin
        // The output register is empty here, so the popped value goes straight in.
        cmd.load_rd = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_DUMP: begin
        // Keep one read in flight and hand it to the output as it frees up.
        cmd.load_rd = sts.rd_pend && sts.out_free;
        cmd.rd_dump = sts.dump_more && (!sts.rd_pend || cmd.load_rd);
        if (cmd.load_rd && sts.rd_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // In the pop state the output register is always empty.
  a_pop_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> !sts.out_valid)
    else $error("pop result blocked by a waiting result");

  // A successful pop is followed directly by its result load.
  a_pop_then_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop_front || cmd.pop_back) |=> cmd.load_rd)
    else $error("pop result not loaded");

  // Dump reads are only issued while entries remain.
  a_dump_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_dump |-> (sts.dump_more && state_r == S_DUMP))
    else $error("dump read past the last entry");
`endif

endmodule

// ===== sv/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed 32-bit values.
//
// Usage: each input transaction carries a command in in_tuser (push front,
// push back, pop front, pop back, dump) and a value in in_tdata, used by
// pushes only. Every command except an unused code gives one or more result
// transactions on the out_ channel; out_tlast marks the final one.
// A push or an error result is registered and appears in the cycle after the
// input transaction. A pop reads the ring memory into a read register and then
// loads the result register; the next command can be accepted only after the
// pop has loaded its result. A dump streams the held entries from front to
// back through the same read register, one per cycle while the receiver
// takes them; input stays blocked until the last entry has been loaded.
// Pushes and error replies sustain one command per cycle while the receiver
// takes each result; the registered memory read sets the pop and dump timing.
// Reset clears the pointers and count, leaving the queue empty; the ring
// contents are not cleared and there is no clearing pass.
// When the receiver stalls, the result register holds its transaction and
// in_tready drops until it is taken, so no result is lost.
`timescale 1ns / 1ps

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[31:0]
  input  logic [2:0]  in_tuser,   // command[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // value_res[31:0], entry_count[36:32], zero fill
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast   // last
);
  import deq_pkg::*;

  cmd_t                cmd;
  sts_t                sts;
  logic [VALUE_W-1:0]  out_value;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_command (in_tuser),
    .sts        (sts),
    .cmd        (cmd)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_value   (in_tdata),
    .out_tready (out_tready),
    .out_valid  (out_tvalid),
    .out_value  (out_value),
    .out_status (out_status),
    .out_count  (out_count),
    .out_last   (out_tlast)
  );

  // Pack the result fields onto the stream.
  assign out_tdata = {3'b000, out_count, out_value};
  assign out_tuser = out_status;

endmodule
